[hdl/pdfx_pkg.sv]
// shared types, codes and constants for the pdf text object string extractor
package pdfx_pkg;

  // scanner modes, one-hot
  typedef enum logic [3:0] {
    MODE_OUTSIDE = 4'b0001,
    MODE_OBJECT  = 4'b0010,
    MODE_STRING  = 4'b0100,
    MODE_STOPPED = 4'b1000
  } mode_t;

  // result kinds
  localparam logic [2:0] KIND_TEXT          = 3'd0;
  localparam logic [2:0] KIND_STRING_END    = 3'd1;
  localparam logic [2:0] KIND_DROP_STRING   = 3'd2;
  localparam logic [2:0] KIND_COMMIT_OBJECT = 3'd3;
  localparam logic [2:0] KIND_DROP_OBJECT   = 3'd4;
  localparam logic [2:0] KIND_OK            = 3'd5;
  localparam logic [2:0] KIND_NO_TEXT       = 3'd6;
  localparam logic [2:0] KIND_BAD_HEADER    = 3'd7;

  // characters
  localparam logic [7:0] CHAR_B      = 8'h42;
  localparam logic [7:0] CHAR_E      = 8'h45;
  localparam logic [7:0] CHAR_T      = 8'h54;
  localparam logic [7:0] CHAR_OPEN   = 8'h28;
  localparam logic [7:0] CHAR_CLOSE  = 8'h29;
  localparam logic [7:0] CHAR_NUL    = 8'h00;

  // header check: seven magic bytes, at least eight bytes in the file
  localparam logic [3:0] HDR_MAGIC_LEN = 4'd7;
  localparam logic [3:0] HDR_MIN_LEN   = 4'd8;

  localparam int unsigned MAX_RESULTS = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } byte_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] text_byte;
    logic       last_result;
  } result_item_t;

  typedef struct packed {
    logic [1:0]                          count;
    result_item_t [MAX_RESULTS-1:0]      item;
  } result_set_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] previous_byte;
    logic [3:0] header_position;
    logic       header_bad;
    logic       string_nonempty;
    logic       object_has_text;
    logic       any_text_committed;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    mode:               MODE_OUTSIDE,
    previous_byte:      8'h00,
    header_position:    4'd0,
    header_bad:         1'b0,
    string_nonempty:    1'b0,
    object_has_text:    1'b0,
    any_text_committed: 1'b0
  };

  // expected header byte at a given position ("%PDF-1.")
  function automatic logic [7:0] magic_byte(input logic [2:0] pos);
    logic [7:0] val;
    case (pos)
      3'd0:    val = 8'h25;
      3'd1:    val = 8'h50;
      3'd2:    val = 8'h44;
      3'd3:    val = 8'h46;
      3'd4:    val = 8'h2d;
      3'd5:    val = 8'h31;
      3'd6:    val = 8'h2e;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  function automatic result_item_t make_result(input logic [2:0] kind,
                                               input logic [7:0] text_byte);
    result_item_t r;
    r.kind        = kind;
    r.text_byte   = text_byte;
    r.last_result = 1'b0;
    return r;
  endfunction

endpackage

[hdl/pdfx_step.sv]
// next-state and result logic for one file byte
module pdfx_step (
  input  pdfx_pkg::scan_state_t state,
  input  pdfx_pkg::byte_item_t  item,
  output pdfx_pkg::scan_state_t state_next,
  output pdfx_pkg::result_set_t results
);
  import pdfx_pkg::*;

  logic         et_pair;
  logic         bt_pair;
  logic [7:0]   b;
  logic [1:0]   n;
  scan_state_t  s;
  result_item_t [MAX_RESULTS-1:0] r;

  assign b       = item.data_byte;
  assign et_pair = (state.previous_byte == CHAR_E) && (b == CHAR_T);
  assign bt_pair = (state.previous_byte == CHAR_B) && (b == CHAR_T);

  always_comb begin
    s = state;
    n = 2'd0;
    r = '0;

    // header check
    if (state.header_position < HDR_MAGIC_LEN &&
        b != magic_byte(state.header_position[2:0])) begin
      s.header_bad = 1'b1;
    end
    if (state.header_position < HDR_MIN_LEN) begin
      s.header_position = state.header_position + 4'd1;
    end

    if (state.mode != MODE_STOPPED) begin
      if (b == CHAR_NUL) begin
        if (state.mode == MODE_OBJECT || state.mode == MODE_STRING) begin
          r[n] = make_result(KIND_DROP_OBJECT, 8'h00);
          n = n + 2'd1;
        end
        s.mode = MODE_STOPPED;
      end else begin
        case (state.mode)
          MODE_OUTSIDE: begin
            if (bt_pair) begin
              s.mode            = MODE_OBJECT;
              s.object_has_text = 1'b0;
            end
          end
          MODE_OBJECT: begin
            if (et_pair) begin
              r[n] = make_result(KIND_COMMIT_OBJECT, 8'h00);
              n = n + 2'd1;
              if (state.object_has_text) s.any_text_committed = 1'b1;
              s.mode = MODE_OUTSIDE;
            end else if (b == CHAR_OPEN) begin
              s.string_nonempty = 1'b0;
              s.mode            = MODE_STRING;
            end
          end
          MODE_STRING: begin
            if (et_pair) begin
              r[n] = make_result(KIND_DROP_STRING, 8'h00);
              n = n + 2'd1;
              r[n] = make_result(KIND_COMMIT_OBJECT, 8'h00);
              n = n + 2'd1;
              if (state.object_has_text) s.any_text_committed = 1'b1;
              s.mode = MODE_OUTSIDE;
            end else if (b == CHAR_CLOSE) begin
              if (state.string_nonempty) begin
                r[n] = make_result(KIND_STRING_END, 8'h00);
                n = n + 2'd1;
                s.object_has_text = 1'b1;
              end
              s.mode = MODE_OBJECT;
            end else begin
              r[n] = make_result(KIND_TEXT, b);
              n = n + 2'd1;
              s.string_nonempty = 1'b1;
            end
          end
          default: begin
            s.mode = MODE_STOPPED;
          end
        endcase
      end
    end
    s.previous_byte = b;

    // end of file: close any open object, report status, start afresh
    if (item.end_of_file) begin
      if (s.mode == MODE_OBJECT || s.mode == MODE_STRING) begin
        r[n] = make_result(KIND_DROP_OBJECT, 8'h00);
        n = n + 2'd1;
      end
      if (s.header_bad || s.header_position < HDR_MIN_LEN) begin
        r[n] = make_result(KIND_BAD_HEADER, 8'h00);
      end else if (s.any_text_committed) begin
        r[n] = make_result(KIND_OK, 8'h00);
      end else begin
        r[n] = make_result(KIND_NO_TEXT, 8'h00);
      end
      n = n + 2'd1;
      s = SCAN_RESET;
    end

    if (n != 2'd0) begin
      r[n - 2'd1].last_result = 1'b1;
    end
  end

  assign state_next    = s;
  assign results.count = n;
  assign results.item  = r;

endmodule

[hdl/pdfx_result_buf.sv]
// result register: holds the results of one byte and hands them out one per cycle while result_stall is low
module pdfx_result_buf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  pdfx_pkg::result_set_t  results,
  output logic                   free,
  output logic                   result_valid,
  input  logic                   result_stall,
  output pdfx_pkg::result_item_t result
);
  import pdfx_pkg::*;

  result_item_t [MAX_RESULTS-1:0] entry;
  logic [1:0] remaining;
  logic [1:0] rd_idx;
  logic       xfer;

  assign result_valid = (remaining != 2'd0);
  assign result       = entry[rd_idx];
  assign xfer         = result_valid && !result_stall;
  // free when empty, or once the last held result goes this cycle
  assign free         = (remaining == 2'd0) || (remaining == 2'd1 && xfer);

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= 2'd0;
      rd_idx    <= 2'd0;
    end else if (load) begin
      remaining <= results.count;
      rd_idx    <= 2'd0;
    end else if (xfer) begin
      remaining <= remaining - 2'd1;
      rd_idx    <= rd_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entry <= results.item;
    end
  end

endmodule

[hdl/pdf_text_object_string_extractor.sv]
// top level: byte input register, scanner state, step logic and result register
// path: a transferred byte passes through the input register, then its results through the result register
// throughput: one byte per cycle while each byte gives at most one result and
//   result_stall is low; a byte giving k results (k is at most 3) stalls the input
//   until the result register, handing out one result at a time, sends its last
// reset: synchronous rst empties the input and result registers and returns
//   the scanner to outside-object with a fresh header check
module pdf_text_object_string_extractor (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   byte_valid,
  output logic                   byte_stall,
  input  pdfx_pkg::byte_item_t   byte_data,
  output logic                   result_valid,
  input  logic                   result_stall,
  output pdfx_pkg::result_item_t result
);
  import pdfx_pkg::*;

  // input register
  logic        in_full;
  byte_item_t  in_q;
  logic        byte_xfer;
  logic        advance;

  // scanner state
  scan_state_t state;
  scan_state_t state_next;
  result_set_t results;
  logic        buf_free;

  // a held byte moves on once the result register can take its results
  assign advance    = in_full && buf_free;
  assign byte_stall = in_full && !buf_free;
  assign byte_xfer  = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= byte_xfer || (in_full && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (byte_xfer) begin
      in_q <= byte_data;
    end
  end

  // scanner state only moves when a byte is stepped
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SCAN_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // one byte's worth of scanning: header check, object and string tracking
  pdfx_step u_step (
    .state      (state),
    .item       (in_q),
    .state_next (state_next),
    .results    (results)
  );

  // up to three results per byte, handed out in order
  pdfx_result_buf u_result_buf (
    .clk          (clk),
    .rst          (rst),
    .load         (advance),
    .results      (results),
    .free         (buf_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

[hdl/pdfx_checker.sv]
// port-level assertions for the extractor, bound to the top level
module pdfx_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   byte_stall,
  input logic                   result_valid,
  input logic                   result_stall,
  input pdfx_pkg::result_item_t result
);
  import pdfx_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // nothing pending straight after reset
  assert property (@(posedge clk) rst |=> !result_valid && !byte_stall)
    else $error("output not empty after reset");

  // only text results carry a byte
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.kind == KIND_TEXT || result.text_byte == 8'h00))
    else $error("non-text result with nonzero byte");

  // a status result closes the byte's results
  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.kind == KIND_OK || result.kind == KIND_NO_TEXT ||
                     result.kind == KIND_BAD_HEADER) |-> result.last_result)
    else $error("status result not marked last");

  // the input is only held back while results are still waiting
  assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> result_valid)
    else $error("input stalled with empty result register");

endmodule

bind pdf_text_object_string_extractor pdfx_checker u_pdfx_checker (
  .clk          (clk),
  .rst          (rst),
  .byte_stall   (byte_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
